// ----- sv/ase_pkg.sv -----
// shared types and constants for the array statistics engine
package ase_pkg;

  localparam int MAX_COUNT_DEF = 64;
  localparam int SAMPLE_W      = 8;
  localparam int COUNT_W       = 7;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                final_req;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] maximum;
    logic [SAMPLE_W-1:0] minimum;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] median;
    logic [COUNT_W-1:0]  count;
    logic                overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_STEP,
    ST_DIV,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic acc_en;
    logic search_init;
    logic sweep_rd;
    logic bit_step;
    logic div_init;
    logic div_step;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic bit_zero;
    logic div_last;
  } status_t;

endpackage

// ----- sv/array_statistics_engine_unit.sv -----
// array statistics engine: max, min, floor mean and median of a sample set
// samples are taken one per cycle while idle; the request with final_req closes the set
// after the closing request: 8 median search sweeps over the store, each a read of every stored
// sample, a drain and a bit step, then 8 + clog2(MAX_COUNT + 1) divide steps, then the result load
// a pending result waits in the output register while the next set is loaded
// synchronous reset empties the set and clears the result valid; store contents are left as is
module array_statistics_engine_unit import ase_pkg::*; #(
  parameter int MAX_COUNT = MAX_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  in_item_t  req_data,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_item_t rsp_data
);

  cmd_t    cmd;
  status_t status;

  ase_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .final_req (req_data.final_req),
    .rsp_ready (rsp_ready),
    .status    (status),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .cmd       (cmd)
  );

  ase_datapath #(
    .MAX_COUNT (MAX_COUNT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req_data (req_data),
    .cmd      (cmd),
    .status   (status),
    .result   (rsp_data)
  );

endmodule

// ----- sv/ase_ram.sv -----
// generic simple dual-port ram with registered read
module ase_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/ase_datapath.sv -----
// sample store, running statistics, median search counters and mean divider
module ase_datapath import ase_pkg::*; #(
  parameter int MAX_COUNT = MAX_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  req_data,
  input  cmd_t      cmd,
  output status_t   status,
  output out_item_t result
);

  localparam int CW = $clog2(MAX_COUNT + 1);
  localparam int AW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
  localparam int SW = SAMPLE_W + CW;
  localparam int DW = (SW > 1) ? $clog2(SW) : 1;
  localparam logic [CW-1:0] FULL = CW'(MAX_COUNT);

  logic [CW-1:0]       count;
  logic [SW-1:0]       sum;
  logic [SAMPLE_W-1:0] run_max;
  logic [SAMPLE_W-1:0] run_min;
  logic                dropped;

  logic [CW-1:0]       ptr;
  logic                rd_valid;
  logic [SAMPLE_W-1:0] rd_data;
  logic [2:0]          bit_idx;
  logic [SAMPLE_W-1:0] acc_lo;
  logic [SAMPLE_W-1:0] acc_hi;
  logic [CW-1:0]       cnt_lo;
  logic [CW-1:0]       cnt_hi;
  logic [DW-1:0]       div_cnt;
  logic [CW-1:0]       rem;
  logic [SW-1:0]       quo;

  logic                store_en;
  logic [CW-1:0]       k_lo;
  logic [CW-1:0]       k_hi;
  logic [SAMPLE_W-1:0] mask;
  logic [SAMPLE_W-1:0] bit_sel;
  logic [SAMPLE_W-1:0] thr_lo;
  logic [SAMPLE_W-1:0] thr_hi;
  logic [CW:0]         r_sh;
  logic [CW:0]         r_sub;
  logic                fits;
  logic [CW-1:0]       rem_next;
  logic [SAMPLE_W:0]   median_sum;
  logic [CW+COUNT_W-1:0] count_ext;

  assign store_en = cmd.acc_en && (count != FULL);

  ase_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (store_en),
    .waddr (count[AW-1:0]),
    .wdata (req_data.sample),
    .re    (cmd.sweep_rd),
    .raddr (ptr[AW-1:0]),
    .rdata (rd_data)
  );

  // order statistic ranks of the two middle elements (equal for odd count)
  assign k_lo = (count - CW'(1)) >> 1;
  assign k_hi = count >> 1;

  // trial threshold: decided upper bits, current bit zero, lower bits ones
  assign mask    = ~(8'hFF << bit_idx);
  assign bit_sel = 8'd1 << bit_idx;
  assign thr_lo  = acc_lo | mask;
  assign thr_hi  = acc_hi | mask;

  // restoring division, one quotient bit per step
  assign r_sh     = {rem, quo[SW-1]};
  assign fits     = r_sh >= {1'b0, count};
  assign r_sub    = r_sh - {1'b0, count};
  assign rem_next = fits ? r_sub[CW-1:0] : r_sh[CW-1:0];

  assign status.sweep_last = (ptr == count - CW'(1));
  assign status.bit_zero   = (bit_idx == 3'd0);
  assign status.div_last   = (div_cnt == DW'(SW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      sum      <= '0;
      run_max  <= '0;
      run_min  <= '1;
      dropped  <= 1'b0;
      ptr      <= '0;
      rd_valid <= 1'b0;
      bit_idx  <= 3'd7;
      acc_lo   <= '0;
      acc_hi   <= '0;
      cnt_lo   <= '0;
      cnt_hi   <= '0;
      div_cnt  <= '0;
      rem      <= '0;
      quo      <= '0;
    end else begin
      rd_valid <= cmd.sweep_rd;
      if (cmd.acc_en) begin
        if (store_en) begin
          count <= count + CW'(1);
          sum   <= sum + SW'(req_data.sample);
          if (req_data.sample > run_max) begin
            run_max <= req_data.sample;
          end
          if (req_data.sample < run_min) begin
            run_min <= req_data.sample;
          end
        end else begin
          dropped <= 1'b1;
        end
      end
      if (cmd.search_init) begin
        acc_lo  <= '0;
        acc_hi  <= '0;
        bit_idx <= 3'd7;
        cnt_lo  <= '0;
        cnt_hi  <= '0;
        ptr     <= '0;
      end
      if (cmd.sweep_rd) begin
        ptr <= status.sweep_last ? '0 : ptr + CW'(1);
      end
      if (rd_valid) begin
        cnt_lo <= cnt_lo + CW'(rd_data <= thr_lo);
        cnt_hi <= cnt_hi + CW'(rd_data <= thr_hi);
      end
      if (cmd.bit_step) begin
        // too few samples at or below the trial value: this bit must be set
        if (cnt_lo <= k_lo) begin
          acc_lo <= acc_lo | bit_sel;
        end
        if (cnt_hi <= k_hi) begin
          acc_hi <= acc_hi | bit_sel;
        end
        cnt_lo  <= '0;
        cnt_hi  <= '0;
        bit_idx <= bit_idx - 3'd1;
      end
      if (cmd.div_init) begin
        div_cnt <= '0;
        rem     <= '0;
        quo     <= sum;
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt + DW'(1);
        rem     <= rem_next;
        quo     <= {quo[SW-2:0], fits};
      end
      if (cmd.res_load) begin
        count   <= '0;
        sum     <= '0;
        run_max <= '0;
        run_min <= '1;
        dropped <= 1'b0;
      end
    end
  end

  assign median_sum = {1'b0, acc_lo} + {1'b0, acc_hi};
  assign count_ext  = {{COUNT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      result.maximum  <= run_max;
      result.minimum  <= run_min;
      result.mean     <= quo[SAMPLE_W-1:0];
      result.median   <= median_sum[SAMPLE_W:1];
      result.count    <= count_ext[COUNT_W-1:0];
      result.overflow <= dropped;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("stored count exceeds capacity");

  a_drop_full: assert property (@(posedge clk) disable iff (rst) dropped |-> count == FULL)
    else $error("overflow flagged with room left in store");

  a_median_order: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> acc_lo <= acc_hi)
    else $error("lower middle value above upper middle value");

  a_min_max: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> run_min <= run_max)
    else $error("minimum above maximum at result");

  a_read_range: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_rd |=> $past(ptr) < count)
    else $error("sweep read beyond stored samples");

endmodule

// ----- sv/ase_ctrl.sv -----
// control state machine: sample load, median search sweeps, divide, result hand-off
module ase_ctrl import ase_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  input  logic    final_req,
  input  logic    rsp_ready,
  input  status_t status,
  output logic    req_ready,
  output logic    rsp_valid,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    req_ready      = 1'b0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.acc_en = 1'b1;
          if (final_req) begin
            cmd.search_init = 1'b1;
            state_next      = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        cmd.sweep_rd = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_DRAIN;
        end
      end
      // last read data lands in the counters
      ST_DRAIN: begin
        state_next = ST_STEP;
      end
      ST_STEP: begin
        cmd.bit_step = 1'b1;
        if (status.bit_zero) begin
          cmd.div_init = 1'b1;
          state_next   = ST_DIV;
        end else begin
          state_next = ST_SWEEP;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.res_load   = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- tb/array_statistics_engine_unit_tb.sv -----
// self-checking testbench for the array statistics engine unit
module array_statistics_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ase_pkg::*;

  localparam int CAP        = MAX_COUNT_DEF;
  localparam int LONG_HOLD  = 4000;
  localparam int SETTLE     = 8 * (CAP + 2) + 32;
  localparam int ITEM_GOAL  = 1000;
  localparam int DIR_ITEMS  = 24;

  // directed sets: lone extremes, full-scale pair, duplicates, odd and even counts
  localparam logic [DIR_ITEMS*8-1:0] DIR_VALS = {
    8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd5, 8'd3, 8'd9, 8'd10, 8'd2, 8'd2,
    8'd7, 8'd200, 8'd100, 8'd150, 8'd50, 8'd250, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6};
  localparam logic [DIR_ITEMS-1:0] DIR_ENDS = 24'b1101_0100_1000_1000_0100_0001;

  typedef enum int {FILL_ANY, FILL_EXTREME, FILL_NEAR, FILL_FLAT} fill_t;

  typedef struct {
    in_item_t req;
    bit       drain_first;
  } send_slot_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  in_item_t  req_data = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  out_item_t rsp_data;

  send_slot_t  send_queue[$];
  out_item_t   stats_due[$];
  int unsigned mismatch_count = 0;
  int unsigned items_built = 0;
  int unsigned items_taken = 0;
  int unsigned set_index = 0;
  bit          set_start = 1'b1;

  // predicted contents of the set being collected
  logic [7:0]  held[CAP];
  int unsigned held_count = 0;
  logic [13:0] held_sum = '0;
  logic [7:0]  held_max = 8'd0;
  logic [7:0]  held_min = 8'd255;
  logic        held_dropped = 1'b0;

  int unsigned tx_gap = 0;
  bit          tx_burst = 1'b0;
  int unsigned rx_stall = 0;
  bit          rx_burst = 1'b0;
  int unsigned rx_seen = 0;

  array_statistics_engine_unit DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data(rsp_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] median_of_held(int unsigned n);
    logic [7:0] w[CAP];
    logic [7:0] v;
    int         j;
    for (int i = 0; i < n; i++) w[i] = held[i];
    for (int i = 1; i < n; i++) begin
      v = w[i];
      j = i;
      while (j > 0 && w[j-1] > v) begin
        w[j] = w[j-1];
        j--;
      end
      w[j] = v;
    end
    if (n % 2 == 0) return 8'(({1'b0, w[n/2]} + {1'b0, w[n/2-1]}) >> 1);
    return w[n/2];
  endfunction

  function automatic void absorb_request(in_item_t r);
    out_item_t s;
    if (held_count < CAP) begin
      held[held_count] = r.sample;
      held_count++;
      held_sum += 14'(r.sample);
      if (r.sample > held_max) held_max = r.sample;
      if (r.sample < held_min) held_min = r.sample;
    end else begin
      held_dropped = 1'b1;
    end
    if (r.final_req) begin
      s.maximum  = held_max;
      s.minimum  = held_min;
      s.mean     = 8'(held_sum / held_count);
      s.median   = median_of_held(held_count);
      s.count    = 7'(held_count);
      s.overflow = held_dropped;
      stats_due.push_back(s);
      held_count   = 0;
      held_sum     = '0;
      held_max     = 8'd0;
      held_min     = 8'd255;
      held_dropped = 1'b0;
    end
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void check_stats(out_item_t got);
    out_item_t want;
    if (stats_due.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual %h", $time, got);
      mismatch_count++;
      return;
    end
    want = stats_due.pop_front();
    compare_field("maximum", want.maximum, got.maximum);
    compare_field("minimum", want.minimum, got.minimum);
    compare_field("mean", want.mean, got.mean);
    compare_field("median", want.median, got.median);
    compare_field("count", 8'(want.count), 8'(got.count));
    compare_field("overflow", 8'(want.overflow), 8'(got.overflow));
  endfunction

  function automatic void queue_sample(logic [7:0] v, bit last);
    send_slot_t slot;
    slot.req.sample    = v;
    slot.req.final_req = last;
    // some sets wait until the engine has delivered everything before them
    slot.drain_first   = set_start && (set_index % 10 == 5);
    send_queue.push_back(slot);
    set_start = last;
    if (last) set_index++;
    items_built++;
  endfunction

  function automatic void queue_random_set(int unsigned len);
    fill_t      style;
    logic [7:0] base;
    logic [7:0] v;
    style = fill_t'($urandom_range(0, 3));
    base  = 8'($urandom);
    for (int unsigned k = 0; k < len; k++) begin
      case (style)
        FILL_ANY:     v = 8'($urandom);
        FILL_EXTREME: v = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        FILL_NEAR:    v = base ^ 8'($urandom_range(0, 7));
        default:      v = base;
      endcase
      queue_sample(v, k == len - 1);
    end
  endfunction

  // mostly short sets, a few that reach or run past capacity
  function automatic int unsigned draw_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return $urandom_range(1, 6);
    if (pick < 95) return $urandom_range(7, 40);
    return $urandom_range(CAP, CAP + 6);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        absorb_request(req_data);
        items_taken++;
      end
      if (!req_valid || req_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          req_valid <= 1'b0;
        end else if (send_queue.size() != 0 &&
                     !(send_queue[0].drain_first && stats_due.size() != 0)) begin
          req_data  <= send_queue[0].req;
          req_valid <= 1'b1;
          void'(send_queue.pop_front());
          if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 3);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        check_stats(rsp_data);
        rx_seen++;
        if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
        rx_stall = rx_burst ? 0 : $urandom_range(0, 3);
        // long hold so the next set fills up behind the pending result
        if (rx_seen == 20 || rx_seen == 60) rx_stall = LONG_HOLD;
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
      rsp_ready <= (rx_stall == 0);
    end
  end

  initial begin
    for (int k = DIR_ITEMS - 1; k >= 0; k--) begin
      queue_sample(DIR_VALS[8*k +: 8], DIR_ENDS[k]);
    end
    // exactly full, final sample dropped, all-max overflow
    queue_random_set(CAP);
    queue_random_set(CAP + 1);
    for (int k = 0; k < CAP + 6; k++) queue_sample(8'd255, k == CAP + 5);
    while (items_built < ITEM_GOAL) queue_random_set(draw_len());

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (items_taken != items_built || stats_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
